### rtl/core/prs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Projection run segmenter package
// Shared constants and types for the projection run segmenter.
// ============================================================================
package prs_pkg;

    // Default storage sizes.
    localparam int DEF_MAX_BINS   = 1024;
    localparam int DEF_MAX_EXTENT = 1024;

    // Field widths fixed by the interface.
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int OUT_IDX_W = 10;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    typedef logic [CNT_W-1:0]     t_count;

    // Configuration register indexes.
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_AXIS         = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic             RST_AXIS         = 1'b0;

    // Item kinds.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_SCAN  = 1'b1;

    // Axis codes.
    localparam logic AXIS_COLUMNS = 1'b0;
    localparam logic AXIS_ROWS    = 1'b1;

    // Saturation value of a bin count.
    localparam t_count COUNT_MAX = 11'h7FF;

endpackage

### rtl/core/prs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and shows
// the contents before a write at the same edge.
// ============================================================================
module prs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/projection_run_segmenter.sv
`timescale 1ns / 1ps
// ============================================================================
// Projection run segmenter
// Counts ink pixels per column or per row into a bin memory, then walks the
// bins on scan items and reports each count and every closed run of nonzero
// bins.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     i_valid, o_stall, i_func, i_ink           in
//  output    o_valid, i_stall, o_bin_index .. o_scan_last  out
//  config    i_cfg_we, i_cfg_index, i_cfg_data         in
//
//  One item is taken per cycle while o_stall is low; a scan result passes
//  through the stage register and the output register before it leaves. The bin
//  counts sit in a single RAM with a registered read, so each item does one
//  read and at most one write, with a one-entry bypass.
//  After reset and after the last scan item a clearing pass zeroes all
//  MAX_BINS bins, one bin per cycle, while o_stall is held high.
//  A stall on the output holds a scan item in place and stalls the input.
//
module projection_run_segmenter #(
    parameter int MAX_BINS   = prs_pkg::DEF_MAX_BINS,
    parameter int MAX_EXTENT = prs_pkg::DEF_MAX_EXTENT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  prs_pkg::t_cfg_index          i_cfg_index,
    input  logic [prs_pkg::CFG_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic                         i_ink,
    // Output channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [prs_pkg::OUT_IDX_W-1:0] o_bin_index,
    output logic [prs_pkg::CNT_W-1:0]    o_bin_count,
    output logic                         o_run_done,
    output logic [prs_pkg::OUT_IDX_W-1:0] o_run_start,
    output logic [prs_pkg::OUT_IDX_W-1:0] o_run_end,
    output logic                         o_scan_last
);

    import prs_pkg::*;

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int POS_W = $clog2(MAX_EXTENT);
    localparam int DIM_W = $clog2(MAX_EXTENT + 1);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic             r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_axis         <= RST_AXIS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_AXIS:         r_axis         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the image dimensions to 1..MAX_EXTENT.
    logic [31:0]      width32;
    logic [31:0]      height32;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;

    always_comb begin
        if (r_image_width == '0) begin
            width32 = 32'd1;
        end else if (32'(r_image_width) > 32'(MAX_EXTENT)) begin
            width32 = 32'(MAX_EXTENT);
        end else begin
            width32 = 32'(r_image_width);
        end
        if (r_image_height == '0) begin
            height32 = 32'd1;
        end else if (32'(r_image_height) > 32'(MAX_EXTENT)) begin
            height32 = 32'(MAX_EXTENT);
        end else begin
            height32 = 32'(r_image_height);
        end
        dim_w = width32[DIM_W-1:0];
        dim_h = height32[DIM_W-1:0];
    end

    // ------------------------------------------------------------------------
    // Pipeline control.
    // ------------------------------------------------------------------------
    logic             r_clearing;
    logic [BIN_W-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic             r_s1_scan;
    logic             r_s1_wr;
    logic             r_s1_last;
    logic [BIN_W-1:0] r_s1_addr;

    logic             r_out_valid;

    logic             adv;
    logic             in_xfer;
    logic             out_xfer;

    // The stage moves unless a scan result is blocked by a full output.
    assign adv      = !(r_s1_valid && r_s1_scan && r_out_valid && i_stall);
    assign o_stall  = r_clearing || !adv;
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // ------------------------------------------------------------------------
    // Pixel position and bin address of a pixel item.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0] r_pixel_col;
    logic [POS_W-1:0] r_pixel_row;
    logic [POS_W-1:0] n_pixel_col;
    logic [POS_W-1:0] n_pixel_row;

    logic [DIM_W-1:0] col_a;
    logic [DIM_W-1:0] row_a;
    logic [DIM_W-1:0] row_b;
    logic [DIM_W-1:0] col_c;
    logic [DIM_W-1:0] row_c;
    logic [31:0]      pix_bin32;
    logic             pix_in_range;
    logic [BIN_W-1:0] pix_addr;

    always_comb begin
        // A position left beyond a shrunk image wraps first.
        if ({1'b0, r_pixel_col} >= (POS_W + 1)'(dim_w)) begin
            col_a = '0;
            row_a = DIM_W'(r_pixel_row) + DIM_W'(1);
        end else begin
            col_a = DIM_W'(r_pixel_col);
            row_a = DIM_W'(r_pixel_row);
        end
        row_b = (row_a >= dim_h) ? '0 : row_a;

        pix_bin32    = (r_axis == AXIS_ROWS) ? 32'(row_b) : 32'(col_a);
        pix_in_range = pix_bin32 < 32'(MAX_BINS);
        pix_addr     = pix_bin32[BIN_W-1:0];

        // Step to the next pixel in raster order.
        col_c = col_a + DIM_W'(1);
        if (col_c >= dim_w) begin
            row_c       = row_b + DIM_W'(1);
            n_pixel_col = '0;
            n_pixel_row = (row_c >= dim_h) ? '0 : row_c[POS_W-1:0];
        end else begin
            row_c       = row_b;
            n_pixel_col = col_c[POS_W-1:0];
            n_pixel_row = row_b[POS_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Scan position and bin address of a scan item.
    // ------------------------------------------------------------------------
    logic [BIN_W-1:0] r_scan_pos;
    logic [BIN_W-1:0] n_scan_pos;
    logic [31:0]      nb32;
    logic [31:0]      scan_i32;
    logic             scan_last;
    logic [BIN_W-1:0] scan_addr;

    always_comb begin
        nb32 = (r_axis == AXIS_ROWS) ? 32'(dim_h) : 32'(dim_w);
        if (nb32 > 32'(MAX_BINS)) begin
            nb32 = 32'(MAX_BINS);
        end
        // A position past the end scans the last bin and ends the scan.
        scan_i32   = (32'(r_scan_pos) >= nb32) ? (nb32 - 32'd1) : 32'(r_scan_pos);
        scan_last  = (scan_i32 == (nb32 - 32'd1));
        scan_addr  = scan_i32[BIN_W-1:0];
        n_scan_pos = scan_last ? '0 : scan_addr + BIN_W'(1);
    end

    // Position registers advance on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_col <= '0;
            r_pixel_row <= '0;
            r_scan_pos  <= '0;
        end else if (in_xfer) begin
            if (i_func == FUNC_PIXEL) begin
                r_pixel_col <= n_pixel_col;
                r_pixel_row <= n_pixel_row;
            end else begin
                r_scan_pos <= n_scan_pos;
                if (scan_last) begin
                    r_pixel_col <= '0;
                    r_pixel_row <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Bin count memory.
    // ------------------------------------------------------------------------
    logic             ram_wr_en;
    logic [BIN_W-1:0] ram_wr_addr;
    t_count           ram_wr_data;
    logic [BIN_W-1:0] ram_rd_addr;
    t_count           ram_rd_data;

    logic             r_fwd_valid;
    logic [BIN_W-1:0] r_fwd_addr;
    t_count           r_fwd_data;

    t_count           s1_count;
    t_count           s1_count_inc;

    assign ram_rd_addr = (i_func == FUNC_SCAN) ? scan_addr : pix_addr;

    // Bypass the write that landed at the same edge as this item's read.
    assign s1_count     = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data
                                                                     : ram_rd_data;
    assign s1_count_inc = (s1_count == COUNT_MAX) ? s1_count : s1_count + 1'b1;

    // The clearing pass owns the write port; no pixel is in flight then.
    always_comb begin
        if (r_clearing) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = adv && r_s1_valid && r_s1_wr;
            ram_wr_addr = r_s1_addr;
            ram_wr_data = s1_count_inc;
        end
    end

    prs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (adv),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Bypass register tracks the write made as the item leaves the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (adv) begin
            r_fwd_valid <= r_s1_valid && r_s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= s1_count_inc;
        end
    end

    // Clearing pass after reset and after the last scan item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_BIN) begin
                r_clearing <= 1'b0;
            end
        end else if (in_xfer && (i_func == FUNC_SCAN) && scan_last) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // Stage register between the memory read and the result.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_scan <= (i_func == FUNC_SCAN);
            r_s1_wr   <= (i_func == FUNC_PIXEL) && i_ink && pix_in_range;
            r_s1_last <= scan_last;
            r_s1_addr <= ram_rd_addr;
        end
    end

    // ------------------------------------------------------------------------
    // Run tracking over the scanned bins.
    // ------------------------------------------------------------------------
    logic             r_in_run;
    logic [BIN_W-1:0] r_open_start;
    logic             s1_take;
    logic             run_close;

    assign s1_take   = adv && r_s1_valid && r_s1_scan;
    assign run_close = r_in_run && (s1_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_open_start <= '0;
        end else if (s1_take) begin
            if (r_s1_last) begin
                r_in_run     <= 1'b0;
                r_open_start <= '0;
            end else if (!r_in_run && (s1_count != '0)) begin
                r_in_run     <= 1'b1;
                r_open_start <= r_s1_addr;
            end else if (run_close) begin
                r_in_run <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    logic [31:0] s1_index32;
    logic [31:0] open_start32;

    logic [OUT_IDX_W-1:0] r_bin_index;
    t_count               r_bin_count;
    logic                 r_run_done;
    logic [OUT_IDX_W-1:0] r_run_start;
    logic [OUT_IDX_W-1:0] r_run_end;
    logic                 r_scan_last;

    assign s1_index32   = 32'(r_s1_addr);
    assign open_start32 = 32'(r_open_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_bin_index <= s1_index32[OUT_IDX_W-1:0];
            r_bin_count <= s1_count;
            r_run_done  <= run_close;
            r_run_start <= run_close ? open_start32[OUT_IDX_W-1:0] : '0;
            r_run_end   <= run_close ? s1_index32[OUT_IDX_W-1:0] : '0;
            r_scan_last <= r_s1_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_bin_index = r_bin_index;
    assign o_bin_count = r_bin_count;
    assign o_run_done  = r_run_done;
    assign o_run_start = r_run_start;
    assign o_run_end   = r_run_end;
    assign o_scan_last = r_scan_last;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Projection run segmenter testbench
// Feeds binarized pixels and scan steps through the input channel, stalls the
// output channel at random, and checks every bin report against a model of
// the bin counts, the pixel position and the open run kept in the bench.
// ============================================================================
module tb;
    import prs_pkg::*;

    localparam int MAX_BINS      = DEF_MAX_BINS;
    localparam int MAX_EXTENT    = DEF_MAX_EXTENT;
    localparam int RAND_ITEMS    = 790;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 10000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SCRIPT_ROWS   = 23;
    localparam int PEND_DEPTH    = 16;

    // Register index with no register behind it.
    localparam t_cfg_index CFG_SPARE = 2'd3;

    // One bin report as it leaves the block.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] bin_idx;
        logic [CNT_W-1:0]     bin_cnt;
        logic                 run_done;
        logic [OUT_IDX_W-1:0] run_start;
        logic [OUT_IDX_W-1:0] run_end;
        logic                 scan_last;
    } t_bin_report;

    typedef enum logic {ROW_WRITE, ROW_ITEMS} t_row_kind;

    // One row of the directed script: a register write or a run of items.
    typedef struct packed {
        t_row_kind        kind;
        t_cfg_index       reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic             func;
        logic             ink;
        logic             ink_rand;
        int               reps;
        logic             typed;
        t_bin_report      want;
    } t_script_row;

    typedef enum int {RX_FLOW, RX_SPARSE, RX_PERIODIC, RX_CHOPPY} t_rx_mode;

    // Block ports.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    t_cfg_index           i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_func      = FUNC_PIXEL;
    logic                 i_ink       = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [OUT_IDX_W-1:0] o_bin_index;
    logic [CNT_W-1:0]     o_bin_count;
    logic                 o_run_done;
    logic [OUT_IDX_W-1:0] o_run_start;
    logic [OUT_IDX_W-1:0] o_run_end;
    logic                 o_scan_last;

    // Model state of the block.
    logic [CNT_W-1:0] ink_hist [MAX_BINS];
    logic [CFG_W-1:0] reg_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0] reg_height = RST_IMAGE_HEIGHT;
    logic             reg_axis   = RST_AXIS;
    int unsigned      col_pos    = 0;
    int unsigned      row_pos    = 0;
    int unsigned      scan_ptr   = 0;
    int unsigned      run_first  = 0;
    logic             run_open   = 1'b0;

    // Reports still owed by the block, oldest first, in a ring.
    t_bin_report pend_fifo [PEND_DEPTH];
    int pend_head = 0;
    int pend_tail = 0;

    int mismatch_count = 0;
    int reports_seen   = 0;
    int pixel_xfers    = 0;
    int scan_xfers     = 0;
    int reg_writes     = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    t_rx_mode rx_mode  = RX_FLOW;
    int rx_left        = 0;

    projection_run_segmenter i_dut (.*);

    // 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic odds(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Number of reports still owed.
    function automatic int pend_count();
        return pend_tail - pend_head;
    endfunction

    // A width or height as the block uses it.
    function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_EXTENT) return MAX_EXTENT;
        return 32'(v);
    endfunction

    function automatic int unsigned bins_now();
        int unsigned n;
        n = (reg_axis == AXIS_ROWS) ? eff_dim(reg_height) : eff_dim(reg_width);
        return (n > MAX_BINS) ? MAX_BINS : n;
    endfunction

    // Scan steps still needed to reach the last bin.
    function automatic int unsigned scan_steps_left();
        int unsigned nb;
        nb = bins_now();
        return (scan_ptr >= nb) ? 1 : nb - scan_ptr;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p == 0) return '0;
        if (p <= 3) return CFG_W'($urandom_range(13, 48));
        return CFG_W'($urandom_range(1, 12));
    endfunction

    // Adds one pixel to its column or row bin and steps the raster position.
    function automatic void count_pixel(logic ink);
        int unsigned w, h, b;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        b = (reg_axis == AXIS_ROWS) ? row_pos : col_pos;
        if (ink && b < MAX_BINS && ink_hist[b] != COUNT_MAX) ink_hist[b] = ink_hist[b] + 1'b1;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // Reports the next bin, tracks the open run and clears after the last bin.
    function automatic t_bin_report scan_bin();
        int unsigned nb, i;
        t_bin_report r;
        nb = bins_now();
        i  = (scan_ptr >= nb) ? nb - 1 : scan_ptr;
        r  = '0;
        r.bin_idx = OUT_IDX_W'(i);
        r.bin_cnt = ink_hist[i];
        if (!run_open && r.bin_cnt != 0) begin
            run_open  = 1'b1;
            run_first = i;
        end else if (run_open && r.bin_cnt == 0) begin
            r.run_done  = 1'b1;
            r.run_start = OUT_IDX_W'(run_first);
            r.run_end   = OUT_IDX_W'(i);
            run_open    = 1'b0;
        end
        r.scan_last = (i == nb - 1);
        if (r.scan_last) begin
            foreach (ink_hist[k]) ink_hist[k] = '0;
            scan_ptr  = 0;
            run_open  = 1'b0;
            run_first = 0;
            col_pos   = 0;
            row_pos   = 0;
        end else begin
            scan_ptr = i + 1;
        end
        return r;
    endfunction

    // Script row builders.
    function automatic t_script_row reg_row(t_cfg_index idx, int val);
        t_script_row row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = CFG_W'(val);
        return row;
    endfunction

    function automatic t_script_row item_row(logic func, logic ink, logic ink_rand, int reps);
        t_script_row row;
        row          = '0;
        row.kind     = ROW_ITEMS;
        row.func     = func;
        row.ink      = ink;
        row.ink_rand = ink_rand;
        row.reps     = reps;
        return row;
    endfunction

    function automatic t_script_row known_scan(int idx, int cnt, int done, int rs, int re,
                                               int last);
        t_script_row row;
        row       = item_row(FUNC_SCAN, 1'b0, 1'b0, 1);
        row.typed = 1'b1;
        row.want  = {OUT_IDX_W'(idx), CNT_W'(cnt), done[0], OUT_IDX_W'(rs), OUT_IDX_W'(re),
                     last[0]};
        return row;
    endfunction

    // Sends one item in bursts with random gaps and updates the model on transfer.
    task automatic send_item(input logic func, input logic ink, input logic typed,
                             input t_bin_report want);
        int   gap;
        logic took;
        t_bin_report rep;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_func  <= func;
        i_ink   <= ink;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (o_stall === 1'b0);
            @(posedge i_clk);
        end
        if (func == FUNC_SCAN) begin
            rep = scan_bin();
            pend_fifo[pend_tail % PEND_DEPTH] = typed ? want : rep;
            pend_tail++;
            scan_xfers++;
        end else begin
            count_pixel(ink);
            pixel_xfers++;
        end
    endtask

    // Waits until every report is in and the block no longer holds off input.
    task automatic settle();
        logic free;
        i_valid <= 1'b0;
        burst_left = 0;
        while (pend_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        free = 1'b0;
        while (!free) begin
            @(negedge i_clk);
            free = (o_stall === 1'b0);
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = val;
            CFG_IMAGE_HEIGHT: reg_height = val;
            CFG_AXIS:         reg_axis   = val[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Receiver stall pattern: modes of random length.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FLOW:     i_stall <= 1'b0;
            RX_SPARSE:   i_stall <= odds(20);
            RX_PERIODIC: i_stall <= (rx_left % 3 == 0);
            default:     i_stall <= (rx_left % 40) < 25;
        endcase
    end

    // Compare each output transfer with the oldest pending report.
    always @(negedge i_clk) begin : report_check
        t_bin_report got;
        t_bin_report want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            got = {o_bin_index, o_bin_count, o_run_done, o_run_start, o_run_end, o_scan_last};
            reports_seen++;
            if (pend_count() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Report for bin %0d arrived with none pending.", got.bin_idx);
            end else begin
                want = pend_fifo[pend_head % PEND_DEPTH];
                pend_head++;
                if (got.bin_idx !== want.bin_idx || got.bin_cnt !== want.bin_cnt ||
                    got.run_done !== want.run_done || got.run_start !== want.run_start ||
                    got.run_end !== want.run_end || got.scan_last !== want.scan_last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Expected bin %0d cnt %0d done %0b run %0d..%0d last %0b",
                                 want.bin_idx, want.bin_cnt, want.run_done, want.run_start,
                                 want.run_end, want.scan_last);
                        $display("Actual   bin %0d cnt %0d done %0b run %0d..%0d last %0b",
                                 got.bin_idx, got.bin_cnt, got.run_done, got.run_start,
                                 got.run_end, got.scan_last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(negedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall == 1'b0))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_script_row script [SCRIPT_ROWS];
        int unsigned ink_pct;
        int unsigned n_pix;
        int unsigned n_scan;
        int unsigned style;
        int unsigned rand_items;
        logic        wrote;

        foreach (ink_hist[k]) ink_hist[k] = '0;

        // Directed script. Small image first, then zero and oversized extents,
        // then short walks on rows and on columns.
        script = '{
            reg_row(CFG_IMAGE_WIDTH, 3),
            reg_row(CFG_IMAGE_HEIGHT, 2),
            item_row(FUNC_PIXEL, 1'b1, 1'b0, 1),
            item_row(FUNC_PIXEL, 1'b0, 1'b0, 1),
            item_row(FUNC_PIXEL, 1'b1, 1'b0, 1),
            known_scan(0, 1, 0, 0, 0, 0),
            known_scan(1, 0, 1, 0, 1, 0),
            // The run opened at the last bin is dropped.
            known_scan(2, 1, 0, 0, 0, 1),
            // Counts were cleared by the end of the scan.
            known_scan(0, 0, 0, 0, 0, 0),
            // Zero width acts as one; the scan position is past the end.
            reg_row(CFG_IMAGE_WIDTH, 0),
            known_scan(0, 0, 0, 0, 0, 1),
            // Oversized height acts as the maximum; one bin per row.
            reg_row(CFG_IMAGE_HEIGHT, 2047),
            reg_row(CFG_AXIS, AXIS_ROWS),
            item_row(FUNC_PIXEL, 1'b0, 1'b1, 40),
            item_row(FUNC_SCAN, 1'b0, 1'b1, 12),
            reg_row(CFG_SPARE, 2047),
            reg_row(CFG_AXIS, AXIS_COLUMNS),
            reg_row(CFG_IMAGE_WIDTH, 1024),
            item_row(FUNC_PIXEL, 1'b0, 1'b1, 40),
            item_row(FUNC_SCAN, 1'b1, 1'b0, 5),
            // Shrink the image in the middle of a scan.
            reg_row(CFG_IMAGE_WIDTH, 4),
            item_row(FUNC_SCAN, 1'b0, 1'b0, 1),
            known_scan(0, 0, 0, 0, 0, 0)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_WRITE) begin
                settle();
                write_reg(script[r].reg_idx, script[r].reg_val);
            end else begin
                repeat (script[r].reps)
                    send_item(script[r].func,
                              script[r].ink_rand ? odds(50) : script[r].ink,
                              script[r].typed, script[r].want);
            end
        end

        // Random frames: mostly pixels then a full scan, some with pixels
        // mixed into the scan, some with the scan cut short.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            settle();
            wrote = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_IMAGE_WIDTH, pick_dim());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_IMAGE_HEIGHT, pick_dim());
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 1) == 1)
                write_reg(CFG_AXIS, CFG_W'($urandom_range(0, 2047)));

            case ($urandom_range(0, 3))
                0:       ink_pct = 8;
                1:       ink_pct = 35;
                2:       ink_pct = 70;
                default: ink_pct = 95;
            endcase
            n_pix = $urandom_range(0, 2 * eff_dim(reg_width) * eff_dim(reg_height));
            if (n_pix > 160) n_pix = $urandom_range(40, 160);
            style = $urandom_range(0, 9);

            if (style <= 7) begin
                repeat (n_pix) send_item(FUNC_PIXEL, odds(ink_pct), 1'b0, '0);
                n_scan = scan_steps_left();
                if (style == 7) n_scan = $urandom_range(1, n_scan);
                repeat (n_scan) send_item(FUNC_SCAN, odds(ink_pct), 1'b0, '0);
            end else begin
                n_scan = scan_steps_left();
                repeat (n_pix + n_scan)
                    send_item(odds(40) ? FUNC_SCAN : FUNC_PIXEL, odds(ink_pct), 1'b0, '0);
            end
            rand_items += n_pix + n_scan;
        end

        // Let the last reports drain.
        i_valid <= 1'b0;
        while (pend_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixel transfers and %0d scan transfers over %0d register writes;",
                 pixel_xfers, scan_xfers, reg_writes);
        $display("checked %0d bin reports, %0d mismatches.", reports_seen, mismatch_count);
        if (mismatch_count == 0 && pend_count() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
